### sv/cct_pkg.sv
package cct_pkg;

  localparam int CW  = 16;   // coordinate width
  localparam int DW  = 17;   // coordinate relative to the query point
  localparam int EW  = 18;   // difference of two relative coordinates
  localparam int MW  = 34;   // squared distance, unsigned
  localparam int KW  = 35;   // 2x2 cross product
  localparam int AW  = 37;   // twice the signed triangle area
  localparam int PW  = 53;   // first level partial products
  localparam int BW  = 56;   // B and C
  localparam int HW  = 28;   // half of B and C, and the limb width later on
  localparam int DDW = 72;   // D
  localparam int LW  = 24;   // limb width of D
  localparam int SPW = 57;   // square partial products
  localparam int APW = 62;   // A times a limb of D
  localparam int NW  = 112;  // N = B^2 + C^2 and k = 4AD
  localparam int SW  = 32;   // scale squared
  localparam int TW  = 33;   // 2^32 - scale squared
  localparam int QW  = 62;   // last partial products
  localparam int FW  = 148;  // final sums
  localparam int NLIMB = NW / HW;

  localparam logic [15:0] SCALE_RST = 16'd65208;

  typedef struct packed {
    logic ce;
    logic vld;
  } cct_ctl_t;

  typedef struct packed {
    logic signed [CW-1:0] query_y;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_x;
  } cct_item_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic col;
  } cct_res_t;

endpackage

### sv/cct_core.sv
module cct_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cct_pkg::cct_ctl_t      ctl,
  input  cct_pkg::cct_item_t     item,
  input  logic [cct_pkg::SW-1:0] s2,
  input  logic [cct_pkg::TW-1:0] t,
  output cct_pkg::cct_res_t      res
);

  logic [9:1] vld_r;

  // stage 1: shift origin to the query point
  logic signed [cct_pkg::DW-1:0] s1_x_r [3];
  logic signed [cct_pkg::DW-1:0] s1_y_r [3];

  // stage 2
  logic [cct_pkg::MW-1:0]        s2_m_r  [3];
  logic signed [cct_pkg::KW-1:0] s2_k_r  [3];
  logic signed [cct_pkg::EW-1:0] s2_ey_r [3];
  logic signed [cct_pkg::EW-1:0] s2_ex_r [3];

  // stage 3
  logic signed [cct_pkg::PW-1:0] s3_bt_r [3];
  logic signed [cct_pkg::PW-1:0] s3_ct_r [3];
  logic signed [cct_pkg::PW-1:0] s3_dl_r [3];
  logic signed [cct_pkg::PW-1:0] s3_dh_r [3];
  logic signed [cct_pkg::AW-1:0] s3_a_r;

  // stage 4
  logic signed [cct_pkg::BW-1:0]  s4_b_r, s4_c_r;
  logic signed [cct_pkg::DDW-1:0] s4_d_r;
  logic signed [cct_pkg::AW-1:0]  s4_a_r;
  logic [9:4]                     col_r;

  // stage 5
  logic signed [cct_pkg::SPW-1:0] s5_bhh_r, s5_bhl_r, s5_chh_r, s5_chl_r;
  logic [2*cct_pkg::HW-1:0]       s5_bll_r, s5_cll_r;
  logic signed [cct_pkg::APW-1:0] s5_ad_r [3];

  // stage 6
  logic signed [cct_pkg::NW-1:0] s6_n_r, s6_k_r;

  // stage 7
  logic [cct_pkg::QW-1:0]        s7_nt_r [cct_pkg::NLIMB];
  logic signed [cct_pkg::QW-1:0] s7_ks_r [cct_pkg::NLIMB];

  // stage 8
  logic signed [cct_pkg::FW-1:0] s8_nt_r, s8_ks_r;

  // stage 9
  logic inside_r;

  logic signed [cct_pkg::FW-1:0] nt_sum, ks_sum, fin_sum;
  logic signed [cct_pkg::NW-1:0] n_sum, k_sum;
  logic signed [cct_pkg::BW-1:0] b_sum, c_sum;
  logic signed [cct_pkg::DDW-1:0] d_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.ce) begin
      vld_r <= {vld_r[8:1], ctl.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ce) begin
      s1_x_r[0] <= cct_pkg::DW'(item.a_x) - cct_pkg::DW'(item.query_x);
      s1_y_r[0] <= cct_pkg::DW'(item.a_y) - cct_pkg::DW'(item.query_y);
      s1_x_r[1] <= cct_pkg::DW'(item.b_x) - cct_pkg::DW'(item.query_x);
      s1_y_r[1] <= cct_pkg::DW'(item.b_y) - cct_pkg::DW'(item.query_y);
      s1_x_r[2] <= cct_pkg::DW'(item.c_x) - cct_pkg::DW'(item.query_x);
      s1_y_r[2] <= cct_pkg::DW'(item.c_y) - cct_pkg::DW'(item.query_y);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_vtx
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    logic signed [cct_pkg::MW-1:0] sqx, sqy;
    logic signed [cct_pkg::KW-1:0] pa, pb;

    assign sqx = s1_x_r[i] * s1_x_r[i];
    assign sqy = s1_y_r[i] * s1_y_r[i];
    assign pa  = s1_x_r[I2] * s1_y_r[I1];
    assign pb  = s1_x_r[I1] * s1_y_r[I2];

    always_ff @(posedge clk) begin
      if (ctl.ce) begin
        s2_m_r[i]  <= $unsigned(sqx) + $unsigned(sqy);
        s2_k_r[i]  <= pa - pb;
        s2_ey_r[i] <= cct_pkg::EW'(s1_y_r[I2]) - cct_pkg::EW'(s1_y_r[I1]);
        s2_ex_r[i] <= cct_pkg::EW'(s1_x_r[I1]) - cct_pkg::EW'(s1_x_r[I2]);
        s3_bt_r[i] <= $signed({1'b0, s2_m_r[i]}) * s2_ey_r[i];
        s3_ct_r[i] <= $signed({1'b0, s2_m_r[i]}) * s2_ex_r[i];
        s3_dl_r[i] <= $signed({1'b0, s2_m_r[i][16:0]}) * s2_k_r[i];
        s3_dh_r[i] <= $signed({1'b0, s2_m_r[i][33:17]}) * s2_k_r[i];
      end
    end
  end

  always_comb begin
    b_sum = cct_pkg::BW'(s3_bt_r[0]) + cct_pkg::BW'(s3_bt_r[1])
          + cct_pkg::BW'(s3_bt_r[2]);
    c_sum = cct_pkg::BW'(s3_ct_r[0]) + cct_pkg::BW'(s3_ct_r[1])
          + cct_pkg::BW'(s3_ct_r[2]);
    d_sum = '0;
    for (int i = 0; i < 3; i++) begin
      d_sum = d_sum + (cct_pkg::DDW'(s3_dh_r[i]) <<< 17) + cct_pkg::DDW'(s3_dl_r[i]);
    end
  end

  // N = B^2 + C^2 from halves; k = 4AD from limbs of D
  always_comb begin
    n_sum = (cct_pkg::NW'(s5_bhh_r) <<< 56) + (cct_pkg::NW'(s5_bhl_r) <<< 29)
          + $signed(cct_pkg::NW'(s5_bll_r))
          + (cct_pkg::NW'(s5_chh_r) <<< 56) + (cct_pkg::NW'(s5_chl_r) <<< 29)
          + $signed(cct_pkg::NW'(s5_cll_r));
    k_sum = ((cct_pkg::NW'(s5_ad_r[2]) <<< 48) + (cct_pkg::NW'(s5_ad_r[1]) <<< 24)
          + cct_pkg::NW'(s5_ad_r[0])) <<< 2;
  end

  always_comb begin
    nt_sum = '0;
    ks_sum = '0;
    for (int j = 0; j < cct_pkg::NLIMB; j++) begin
      nt_sum = nt_sum + $signed(cct_pkg::FW'(s7_nt_r[j]) << (cct_pkg::HW * j));
      ks_sum = ks_sum + (cct_pkg::FW'(s7_ks_r[j]) <<< (cct_pkg::HW * j));
    end
    fin_sum = s8_nt_r + s8_ks_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ce) begin
      s3_a_r <= -(cct_pkg::AW'(s2_k_r[0]) + cct_pkg::AW'(s2_k_r[1])
                + cct_pkg::AW'(s2_k_r[2]));

      s4_b_r   <= b_sum;
      s4_c_r   <= c_sum;
      s4_d_r   <= d_sum;
      s4_a_r   <= s3_a_r;
      col_r[4] <= (s3_a_r == '0);

      // upper halves are signed
      s5_bhh_r <= $signed(s4_b_r[55:28]) * $signed(s4_b_r[55:28]);
      s5_bhl_r <= $signed(s4_b_r[55:28]) * $signed({1'b0, s4_b_r[27:0]});
      s5_bll_r <= s4_b_r[27:0] * s4_b_r[27:0];
      s5_chh_r <= $signed(s4_c_r[55:28]) * $signed(s4_c_r[55:28]);
      s5_chl_r <= $signed(s4_c_r[55:28]) * $signed({1'b0, s4_c_r[27:0]});
      s5_cll_r <= s4_c_r[27:0] * s4_c_r[27:0];
      s5_ad_r[0] <= s4_a_r * $signed({1'b0, s4_d_r[23:0]});
      s5_ad_r[1] <= s4_a_r * $signed({1'b0, s4_d_r[47:24]});
      s5_ad_r[2] <= s4_a_r * $signed(s4_d_r[71:48]);

      s6_n_r <= n_sum;
      s6_k_r <= k_sum;

      for (int j = 0; j < cct_pkg::NLIMB; j++) begin
        s7_nt_r[j] <= s6_n_r[cct_pkg::HW*j +: cct_pkg::HW] * t;
        if (j == cct_pkg::NLIMB - 1) begin
          s7_ks_r[j] <= $signed(s6_k_r[cct_pkg::HW*j +: cct_pkg::HW])
                      * $signed({1'b0, s2});
        end else begin
          s7_ks_r[j] <= $signed({1'b0, s6_k_r[cct_pkg::HW*j +: cct_pkg::HW]})
                      * $signed({1'b0, s2});
        end
      end

      s8_nt_r <= nt_sum;
      s8_ks_r <= ks_sum;

      // inside when N*(2^32 - s^2) + s^2*4AD < 0
      inside_r   <= !col_r[8] && fin_sum[cct_pkg::FW-1];
      col_r[9:5] <= col_r[8:4];
    end
  end

  assign res.vld = vld_r[9];
  assign res.hit = inside_r;
  assign res.col = col_r[9];

`ifndef NO_ASSERTIONS
  a_col_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
    res.vld && res.col |-> !res.hit)
    else $error("collinear result flagged inside");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.ce |=> $stable(vld_r))
    else $error("pipeline moved during stall");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits survive reset");
`endif

endmodule

### sv/circumcircle_point_test.sv
// channel | ports                         | request
// in      | in_tvalid/in_tready/in_tdata  | a_x..query_y, 16 bits each
// out     | out_tvalid/out_tready/out_*   | inside_res in tdata, collinear in tuser
// cfg     | cfg_we/cfg_wdata              | radius_scale, Q0.16
// One request per cycle while the output is not stalled, through nine register
// stages; the result is valid when it leaves the last stage of the core.
// rst_n is synchronous; it empties the pipeline and sets radius_scale to 0.995.
// A stalled output freezes all stages; nothing is dropped or repeated.
module circumcircle_point_test (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // a_x, a_y, b_x, b_y, c_x, c_y, query_x, query_y
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // inside_res, zero fill
  output logic         out_tuser,  // collinear
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  logic [15:0]                radius_scale_r;
  logic [cct_pkg::SW-1:0]     s2_r;
  logic [cct_pkg::TW-1:0]     t_r;
  cct_pkg::cct_ctl_t          ctl;
  cct_pkg::cct_res_t          res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_scale_r <= cct_pkg::SCALE_RST;
    end else if (cfg_we) begin
      radius_scale_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    s2_r <= radius_scale_r * radius_scale_r;
    t_r  <= {1'b1, {cct_pkg::SW{1'b0}}} - cct_pkg::TW'(s2_r);
  end

  assign ctl.ce  = !res.vld || out_tready;
  assign ctl.vld = in_tvalid;
  assign in_tready = ctl.ce;

  cct_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .item  (cct_pkg::cct_item_t'(in_tdata)),
    .s2    (s2_r),
    .t     (t_r),
    .res   (res)
  );

  assign out_tvalid = res.vld;
  assign out_tdata  = {7'd0, res.hit};
  assign out_tuser  = res.col;

endmodule
